>>> hw/rtl/cfse_pkg.sv
// Package: types, head codes and field constants for the float encoder.
`timescale 1ns / 1ps
package cfse_pkg;
  localparam logic [7:0] HEAD_HALF   = 8'hf9;
  localparam logic [7:0] HEAD_SINGLE = 8'hfa;
  localparam logic [7:0] HEAD_DOUBLE = 8'hfb;
  localparam logic [3:0] LEN_HALF    = 4'd2;
  localparam logic [3:0] LEN_SINGLE  = 4'd4;
  localparam logic [3:0] LEN_DOUBLE  = 4'd8;
  localparam logic [10:0] EXP_MAX    = 11'd2047;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [63:0] payload;
    logic [3:0]  payload_bytes;
    logic        not_finite;
  } result_t;
endpackage

>>> hw/rtl/cfse_if.sv
// Interfaces: input value channel and result channel.
`timescale 1ns / 1ps
interface cfse_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink (input valid, input value_bits, output ready);
endinterface

interface cfse_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  head_byte;
  logic [63:0] payload;
  logic [3:0]  payload_bytes;
  logic        not_finite;
  modport source (output valid, output head_byte, output payload, output payload_bytes,
                  output not_finite, input ready);
  modport sink (input valid, input head_byte, input payload, input payload_bytes,
                input not_finite, output ready);
endinterface

>>> hw/rtl/cfse_classify.sv
// Combinational classifier: picks the shortest exact float encoding, or flags a non-finite value.
`timescale 1ns / 1ps
module cfse_classify (
  input  logic [63:0]      value_bits,
  output cfse_pkg::result_t result
);
  import cfse_pkg::*;

  logic        sign;
  logic [10:0] efield;
  logic [51:0] frac;
  logic [52:0] sig;
  logic [5:0]  sh_half;
  logic [5:0]  sh_single;
  logic [52:0] mask_half;
  logic [52:0] mask_single;
  logic        in_half_norm, in_half_sub, in_single_norm, in_single_sub;
  logic        half_ok, single_ok;
  logic [52:0] sig_half, sig_single;

  assign sign   = value_bits[63];
  assign efield = value_bits[62:52];
  assign frac   = value_bits[51:0];
  assign sig    = {1'b1, frac};

  // Exponent windows on the biased field (bias 1023)
  assign in_half_norm   = (efield >= 11'd1009) && (efield <= 11'd1038);
  assign in_half_sub    = (efield >= 11'd999)  && (efield <= 11'd1008);
  assign in_single_norm = (efield >= 11'd897)  && (efield <= 11'd1150);
  assign in_single_sub  = (efield >= 11'd874)  && (efield <= 11'd896);

  // Shift: half sub 28-e = 1051-efield; single sub -e-97 = 926-efield
  assign sh_half   = 6'(11'd1051 - efield);
  assign sh_single = 6'(11'd926 - efield);
  assign mask_half   = ~(53'h1f_ffff_ffff_ffff << sh_half);
  assign mask_single = ~(53'h1f_ffff_ffff_ffff << sh_single);
  assign sig_half    = sig >> sh_half;
  assign sig_single  = sig >> sh_single;

  assign half_ok = (in_half_norm && frac[41:0] == '0) ||
                   (in_half_sub && (sig & mask_half) == '0);
  assign single_ok = (in_single_norm && frac[28:0] == '0) ||
                     (in_single_sub && (sig & mask_single) == '0);

  // Select the encoding
  always_comb begin
    result = '{head_byte: HEAD_DOUBLE, payload: value_bits,
               payload_bytes: LEN_DOUBLE, not_finite: 1'b0};
    if (efield == EXP_MAX) begin
      result = '{head_byte: 8'h00, payload: 64'h0, payload_bytes: 4'h0, not_finite: 1'b1};
    end else if (efield == '0) begin
      if (frac == '0) begin
        result.head_byte     = HEAD_HALF;
        result.payload       = {48'h0, sign, 15'h0};
        result.payload_bytes = LEN_HALF;
      end
    end else if (half_ok) begin
      result.head_byte     = HEAD_HALF;
      result.payload_bytes = LEN_HALF;
      if (in_half_norm) begin
        result.payload = {48'h0, sign, 5'(efield - 11'd1008), frac[51:42]};
      end else begin
        result.payload = {48'h0, sign, 5'h0, sig_half[9:0]};
      end
    end else if (single_ok) begin
      result.head_byte     = HEAD_SINGLE;
      result.payload_bytes = LEN_SINGLE;
      if (in_single_norm) begin
        result.payload = {32'h0, sign, 8'(efield - 11'd896), frac[51:29]};
      end else begin
        result.payload = {32'h0, sign, 8'h0, sig_single[22:0]};
      end
    end
  end
endmodule

>>> hw/rtl/cbor_float_shortest_encoder.sv
// Top level: CBOR shortest float encoder with input and result registers.
// Path: input register, then result register, from input transaction to result valid.
// Throughput: one transaction per cycle while the sink takes results; the classifier logic sets no extra wait.
// A full result register still accepts input when the sink takes the result.
// Reset: synchronous active-high rst clears both valid flags; payload is not reset.
`timescale 1ns / 1ps
module cbor_float_shortest_encoder (
  input  logic       clk,
  input  logic       rst,
  cfse_in_if.sink    in_ch,
  cfse_out_if.source out_ch
);
  import cfse_pkg::*;

  logic        in_valid;
  logic [63:0] in_bits;
  logic        out_valid;
  result_t     out_res;
  result_t     res_next;
  logic        adv_out;
  logic        adv_in;

  cfse_classify u_classify (.value_bits(in_bits), .result(res_next));

  assign adv_out      = !out_valid || out_ch.ready;
  assign adv_in       = !in_valid || adv_out;
  assign in_ch.ready  = adv_in;

  // Advance the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv_in) begin
      in_valid <= in_ch.valid;
    end
    if (adv_in && in_ch.valid) begin
      in_bits <= in_ch.value_bits;
    end
  end

  // Advance the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= in_valid;
    end
    if (adv_out && in_valid) begin
      out_res <= res_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.head_byte     = out_res.head_byte;
  assign out_ch.payload       = out_res.payload;
  assign out_ch.payload_bytes = out_res.payload_bytes;
  assign out_ch.not_finite    = out_res.not_finite;
endmodule

>>> hw/rtl/cfse_checker.sv
// Checker on the top-level ports, bound to the encoder.
`timescale 1ns / 1ps
module cfse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  head_byte,
  input logic [3:0]  payload_bytes,
  input logic        not_finite
);
  import cfse_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(head_byte))
    else $error("result changed while stalled");

  // Head byte matches the length
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (head_byte == HEAD_HALF && payload_bytes == LEN_HALF) ||
                  (head_byte == HEAD_SINGLE && payload_bytes == LEN_SINGLE) ||
                  (head_byte == HEAD_DOUBLE && payload_bytes == LEN_DOUBLE) ||
                  (not_finite && head_byte == 8'h00 && payload_bytes == 4'h0))
    else $error("head and length disagree");

  // Take input whenever the output side drains
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled with output ready");

  // An accepted transaction, followed by a ready output, makes the result valid
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("result missing");
endmodule

bind cbor_float_shortest_encoder cfse_checker u_cfse_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .head_byte(out_ch.head_byte), .payload_bytes(out_ch.payload_bytes),
  .not_finite(out_ch.not_finite)
);

>>> dv/cbor_float_shortest_encoder_test.sv
// Testbench: random and directed binary64 values checked against a bit-field predictor.
`timescale 1ns / 1ps
module cbor_float_shortest_encoder_test;
  import cfse_pkg::*;

  logic clk;
  logic rst;
  cfse_in_if  in_ch ();
  cfse_out_if out_ch ();

  cbor_float_shortest_encoder dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  logic [63:0] pending_values[$];
  result_t     expected_encodings[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;
  logic        in_taken = 1'b0;

  // Clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Work out the shortest exact encoding of one double
  function automatic result_t encode_shortest(logic [63:0] bits);
    result_t     r;
    logic        sgn;
    logic [10:0] ef;
    logic [51:0] frac;
    logic [52:0] sig;
    int          e;
    int          sh;
    sgn  = bits[63];
    ef   = bits[62:52];
    frac = bits[51:0];
    sig  = {1'b1, frac};
    r.head_byte = HEAD_DOUBLE;
    r.payload = bits;
    r.payload_bytes = LEN_DOUBLE;
    r.not_finite = 1'b0;
    if (ef == EXP_MAX) begin
      r.head_byte = 8'h00;
      r.payload = 64'h0;
      r.payload_bytes = 4'd0;
      r.not_finite = 1'b1;
      return r;
    end
    if (ef == 11'd0) begin
      if (frac == 52'd0) begin
        r.head_byte = HEAD_HALF;
        r.payload = {48'd0, sgn, 15'd0};
        r.payload_bytes = LEN_HALF;
      end
      return r;
    end
    e = int'(ef) - 1023;
    // half: normal then subnormal
    if (e >= -14 && e <= 15) begin
      if (frac[41:0] == 42'd0) begin
        r.head_byte = HEAD_HALF;
        r.payload = {48'd0, sgn, 5'(e + 15), frac[51:42]};
        r.payload_bytes = LEN_HALF;
        return r;
      end
    end else if (e >= -24 && e < -14) begin
      sh = 28 - e;
      if ((sig & ((53'd1 << sh) - 53'd1)) == 53'd0) begin
        r.head_byte = HEAD_HALF;
        r.payload = {48'd0, sgn, 15'(sig >> sh)};
        r.payload_bytes = LEN_HALF;
        return r;
      end
    end
    // single: normal then subnormal
    if (e >= -126 && e <= 127) begin
      if (frac[28:0] == 29'd0) begin
        r.head_byte = HEAD_SINGLE;
        r.payload = {32'd0, sgn, 8'(e + 127), frac[51:29]};
        r.payload_bytes = LEN_SINGLE;
      end
    end else if (e >= -149 && e < -126) begin
      sh = -e - 97;
      if ((sig & ((53'd1 << sh) - 53'd1)) == 53'd0) begin
        r.head_byte = HEAD_SINGLE;
        r.payload = {32'd0, sgn, 31'(sig >> sh)};
        r.payload_bytes = LEN_SINGLE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Append one value to the send queue
  task automatic queue_value(logic [63:0] v);
    pending_values.insert(pending_values.size(), v);
  endtask

  // Driver: offer queued values, idle at random
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold the offered transaction
    end else if (pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_ch.valid <= 1'b1;
      in_ch.value_bits <= pending_values.pop_front();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Predict on each accepted input transaction
  always @(posedge clk) begin
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready)
      expected_encodings.insert(expected_encodings.size(), encode_shortest(in_ch.value_bits));
  end

  // Receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_encodings.size() == 0) begin
        report_mismatch("unexpected result", out_ch.payload, 64'h0);
      end else begin
        want = expected_encodings.pop_front();
        if (out_ch.head_byte !== want.head_byte)
          report_mismatch("head_byte", 64'(out_ch.head_byte), 64'(want.head_byte));
        if (out_ch.payload !== want.payload)
          report_mismatch("payload", out_ch.payload, want.payload);
        if (out_ch.payload_bytes !== want.payload_bytes)
          report_mismatch("payload_bytes", 64'(out_ch.payload_bytes),
                          64'(want.payload_bytes));
        if (out_ch.not_finite !== want.not_finite)
          report_mismatch("not_finite", 64'(out_ch.not_finite), 64'(want.not_finite));
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycle_count > 200000) begin
      $display("cbor_float_shortest_encoder regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random value biased toward exact half and single encodings
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    int          sel;
    int          e;
    v = rand64();
    sel = $urandom_range(9);
    case (sel)
      0, 1: begin
        e = $urandom_range(15 + 26) - 26;
        v[62:52] = 11'(e + 1023);
        v[41:0] = 42'd0;
        if (e < -14) v[51:0] = v[51:0] & ~((52'd1 << (-14 - e)) - 52'd1) & ~52'h3ffffffffff;
      end
      2, 3: begin
        e = $urandom_range(127 + 151) - 151;
        v[62:52] = 11'(e + 1023);
        v[28:0] = 29'd0;
        if (e < -126) v[51:0] = v[51:0] & ~((52'd1 << (-126 - e + 29)) - 52'd1);
      end
      4: begin
        e = $urandom_range(1) ? $urandom_range(20) - 10 : $urandom_range(20) + 117;
        v[62:52] = 11'(e + 1023);
        v[27:0] = 28'd0;
        v[28] = 1'($urandom_range(1));
      end
      5: v[62:52] = $urandom_range(1) ? EXP_MAX : 11'd0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) queue_value(pick_value());
    wait (pending_values.size() == 0 && !in_ch.valid);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value_bits = 64'h0;
    out_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: zeros, infinities, NaN, subnormals, range edges
    queue_value(64'h0000000000000000);
    queue_value(64'h8000000000000000);
    queue_value(64'h7ff0000000000000);
    queue_value(64'hfff0000000000000);
    queue_value(64'h7ff8000000000001);
    queue_value(64'hffffffffffffffff);
    queue_value(64'h0000000000000001);
    queue_value(64'h800fffffffffffff);
    queue_value(64'h3ff0000000000000);
    queue_value(64'h40effc0000000000);
    queue_value(64'h40f0000000000000);
    queue_value(64'h3f10000000000000);
    queue_value(64'h3e70000000000000);
    queue_value(64'hbe70000000000000);
    queue_value(64'h3e60000000000000);
    queue_value(64'h3f0ff80000000000);
    queue_value(64'h3ff0040000000000);
    queue_value(64'h47efffffe0000000);
    queue_value(64'h47f0000000000000);
    queue_value(64'h3810000000000000);
    queue_value(64'h36a0000000000000);
    queue_value(64'h3690000000000000);
    queue_value(64'h380fffffc0000000);
    queue_value(64'h3ff0000010000000);
    queue_value(64'h7fefffffffffffff);
    wait (pending_values.size() == 0 && !in_ch.valid);

    run_phase(480, 0, 0);
    run_phase(480, 51, 0);
    run_phase(480, 0, 51);
    run_phase(300, 31, 31);

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_off_cycles = 60;
    repeat (160) queue_value(pick_value());
    wait (pending_values.size() == 0 && !in_ch.valid);

    wait (expected_encodings.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_encodings.size() == 0) begin
      $display("cbor_float_shortest_encoder regression: pass");
    end else begin
      $display("cbor_float_shortest_encoder regression: fail");
    end
    $finish;
  end
endmodule

>>> cbor_float_shortest_encoder.f
hw/rtl/cfse_pkg.sv
hw/rtl/cfse_if.sv
hw/rtl/cfse_classify.sv
hw/rtl/cbor_float_shortest_encoder.sv
hw/rtl/cfse_checker.sv
dv/cbor_float_shortest_encoder_test.sv
